>>> rtl/lzsd_pkg.sv
// lzsd_pkg: shared types, codes and default sizes for the lzss stream decoder
// no dependencies; used by every module under rtl except lzsd_fifo
package lzsd_pkg;

   // default token geometry
   localparam int WINDOW_BITS = 13;
   localparam int LENGTH_BITS = 4;
   localparam int MIN_MATCH   = 3;
   localparam int LIT_BITS    = 8;

   // reset value of the output capacity register
   localparam logic [31:0] CAP_RESET = 32'hFFFF_FFFF;

   // queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [0:0] {
      OP_DATA    = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_END      = 2'd1,
      KIND_OVERFLOW = 2'd2
   } rsp_kind_type;

   // work handed from the parser to the copy engine
   typedef enum logic [2:0] {
      CMD_RESTART = 3'd0,
      CMD_LITERAL = 3'd1,
      CMD_COPY    = 3'd2,
      CMD_END     = 3'd3,
      CMD_FAIL    = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   value;
      logic         last;
   } rsp_type;

endpackage

>>> rtl/lzsd_fifo.sv
// lzsd_fifo: small show-ahead register queue with occupancy count
// no package dependencies; used for the command queue and the result queue
module lzsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               rd_data,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/lzsd_front.sv
// lzsd_front: bit parser, stream status and capacity check; one beat per cycle while accept is high
// depends on lzsd_pkg; feeds commands into the command queue
module lzsd_front #(
   parameter int WINDOW_BITS = lzsd_pkg::WINDOW_BITS,
   parameter int LENGTH_BITS = lzsd_pkg::LENGTH_BITS,
   parameter int CMD_W = $bits(lzsd_pkg::cmd_kind_type) + 8 + WINDOW_BITS + LENGTH_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lzsd_pkg::req_type   req_item,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic                cmd_push,
   output logic [CMD_W-1:0]    cmd_data
);

   localparam int TOK_W   = 1 + WINDOW_BITS + LENGTH_BITS;
   localparam int LIT_W   = 1 + lzsd_pkg::LIT_BITS;
   localparam int PEND_W  = WINDOW_BITS + LENGTH_BITS;
   localparam int MERGE_W = PEND_W + 8;
   localparam int CNT_W   = $clog2(MERGE_W + 1);
   localparam int NEED_W  = LENGTH_BITS + 1;

   typedef struct packed {
      lzsd_pkg::cmd_kind_type    kind;
      logic [7:0]                value;
      logic [WINDOW_BITS-1:0]    pos;
      logic [LENGTH_BITS-1:0]    len;
   } cmd_type;

   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic [CNT_W-1:0]    pcnt_ff, pcnt_in;
   logic [31:0]         bytes_ff, bytes_in;
   logic [31:0]         cap_ff, cap_in;
   logic                ended_ff, ended_in;
   logic                failed_ff, failed_in;

   logic [MERGE_W-1:0]     merged, aligned;
   logic [CNT_W-1:0]       mcnt, rest_cnt;
   logic [PEND_W-1:0]      rest;
   logic                   flag, has_lit, has_pos, is_end, has_copy;
   logic [7:0]             lit;
   logic [WINDOW_BITS-1:0] pos;
   logic [LENGTH_BITS-1:0] len;
   logic [NEED_W-1:0]      need;
   logic [32:0]            room;
   logic                   over;
   cmd_type                cmd;

   // token aligned to the top of the merged word
   always_comb begin
      merged   = {pend_ff, req_item.data_byte};
      mcnt     = pcnt_ff + CNT_W'(8);
      aligned  = merged << (CNT_W'(MERGE_W) - mcnt);
      flag     = aligned[MERGE_W-1];
      lit      = aligned[MERGE_W-2 -: 8];
      pos      = aligned[MERGE_W-2 -: WINDOW_BITS];
      len      = aligned[MERGE_W-2-WINDOW_BITS -: LENGTH_BITS];
      has_lit  = flag && (mcnt >= CNT_W'(LIT_W));
      has_pos  = !flag && (mcnt >= CNT_W'(1 + WINDOW_BITS));
      is_end   = has_pos && (pos == '0);
      has_copy = has_pos && (pos != '0) && (mcnt >= CNT_W'(TOK_W));
      need     = has_lit ? NEED_W'(1)
                         : NEED_W'(len) + NEED_W'(lzsd_pkg::MIN_MATCH);
      room     = {1'b0, cap_ff} - {1'b0, bytes_ff};
      over     = room[32] || (room[31:0] < 32'(need));
      rest_cnt = mcnt - (has_lit ? CNT_W'(LIT_W) : CNT_W'(TOK_W));
      rest     = merged[PEND_W-1:0] & ~({PEND_W{1'b1}} << rest_cnt);
   end

   always_comb begin
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      bytes_in  = bytes_ff;
      ended_in  = ended_ff;
      failed_in = failed_ff;
      cap_in    = csr_wr_en ? csr_wr_data : cap_ff;
      cmd_push  = 1'b0;
      cmd.kind  = lzsd_pkg::CMD_RESTART;
      cmd.value = lit;
      cmd.pos   = pos;
      cmd.len   = len;
      if (accept) begin
         if (req_item.op == lzsd_pkg::OP_RESTART) begin
            pend_in   = '0;
            pcnt_in   = '0;
            bytes_in  = '0;
            ended_in  = 1'b0;
            failed_in = 1'b0;
            cmd_push  = 1'b1;
         end else if (!ended_ff && !failed_ff) begin
            if (has_lit || has_copy) begin
               cmd_push = 1'b1;
               if (over) begin
                  cmd.kind  = lzsd_pkg::CMD_FAIL;
                  failed_in = 1'b1;
                  pend_in   = '0;
                  pcnt_in   = '0;
               end else begin
                  cmd.kind = has_lit ? lzsd_pkg::CMD_LITERAL : lzsd_pkg::CMD_COPY;
                  bytes_in = bytes_ff + 32'(need);
                  pend_in  = rest;
                  pcnt_in  = rest_cnt;
               end
            end else if (is_end) begin
               cmd_push = 1'b1;
               cmd.kind = lzsd_pkg::CMD_END;
               ended_in = 1'b1;
               pend_in  = '0;
               pcnt_in  = '0;
            end else begin
               // token incomplete, keep every bit
               pend_in = merged[PEND_W-1:0];
               pcnt_in = mcnt;
            end
         end
      end
   end

   assign cmd_data = CMD_W'(cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         pcnt_ff   <= '0;
         bytes_ff  <= '0;
         ended_ff  <= 1'b0;
         failed_ff <= 1'b0;
         cap_ff    <= lzsd_pkg::CAP_RESET;
      end else begin
         pend_ff   <= pend_in;
         pcnt_ff   <= pcnt_in;
         bytes_ff  <= bytes_in;
         ended_ff  <= ended_in;
         failed_ff <= failed_in;
         cap_ff    <= cap_in;
      end
   end

endmodule

>>> rtl/lzsd_back.sv
// lzsd_back: copy engine with the window memory, head pointer and clear sweep
// depends on lzsd_pkg; drains the command queue, fills the result queue
module lzsd_back #(
   parameter int WINDOW_BITS = lzsd_pkg::WINDOW_BITS,
   parameter int LENGTH_BITS = lzsd_pkg::LENGTH_BITS,
   parameter int RSP_DEPTH   = lzsd_pkg::RSP_DEPTH,
   parameter int CMD_W = $bits(lzsd_pkg::cmd_kind_type) + 8 + WINDOW_BITS + LENGTH_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  logic [CMD_W-1:0]               cmd_data,
   output logic                           cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic                           rsp_push,
   output lzsd_pkg::rsp_type              rsp_item,
   output logic                           clearing
);

   localparam int WIN_DEPTH = 2 ** WINDOW_BITS;
   localparam int RC_W      = $clog2(RSP_DEPTH + 1) + 1;
   localparam int IDX_W     = LENGTH_BITS + 1;

   typedef struct packed {
      lzsd_pkg::cmd_kind_type    kind;
      logic [7:0]                value;
      logic [WINDOW_BITS-1:0]    pos;
      logic [LENGTH_BITS-1:0]    len;
   } cmd_type;

   logic [7:0]             win_mem [WIN_DEPTH];
   logic [7:0]             rd_ff, byp_data_ff;
   logic                   byp_ff;

   logic                   clr_ff, clr_in;
   logic [WINDOW_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [WINDOW_BITS-1:0] head_ff, head_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic                   s2_valid_ff, s2_valid_in;
   lzsd_pkg::cmd_kind_type s2_kind_ff, s2_kind_in;
   logic                   s2_mem_ff, s2_mem_in;
   logic [7:0]             s2_value_ff, s2_value_in;
   logic                   s2_last_ff, s2_last_in;

   cmd_type                cmd;
   logic                   space, issue, is_copy, copy_last;
   logic [WINDOW_BITS-1:0] rd_addr, wr_addr;
   logic                   wr_en, wr_byte;
   logic [7:0]             wr_data, byte_data;

   assign cmd      = cmd_type'(cmd_data);
   assign clearing = clr_ff;

   // stage 1: issue one byte (or one status item) when a command waits, the result queue has room and the sweep is done
   always_comb begin
      space     = (RC_W'(rsp_count) + RC_W'(s2_valid_ff)) < RC_W'(RSP_DEPTH);
      issue     = cmd_valid && space && !clr_ff;
      is_copy   = (cmd.kind == lzsd_pkg::CMD_COPY);
      copy_last = (idx_ff == IDX_W'(cmd.len) + IDX_W'(lzsd_pkg::MIN_MATCH - 1));
      cmd_pop   = issue && (!is_copy || copy_last);
      rd_addr   = cmd.pos + WINDOW_BITS'(idx_ff);
      idx_in    = idx_ff;
      if (issue && is_copy) begin
         idx_in = copy_last ? '0 : idx_ff + 1'b1;
      end
      s2_valid_in = issue;
      s2_kind_in  = cmd.kind;
      s2_mem_in   = is_copy;
      s2_value_in = cmd.value;
      s2_last_in  = !is_copy || copy_last;
   end

   // stage 2: write the byte at the head and hand the result over, or rewind the head on a restart
   always_comb begin
      byte_data = s2_mem_ff ? (byp_ff ? byp_data_ff : rd_ff) : s2_value_ff;
      wr_byte   = 1'b0;
      rsp_push  = s2_valid_ff;
      rsp_item.kind  = lzsd_pkg::KIND_BYTE;
      rsp_item.value = 8'd0;
      rsp_item.last  = s2_last_ff;
      head_in   = head_ff;
      unique case (s2_kind_ff) inside
         lzsd_pkg::CMD_LITERAL, lzsd_pkg::CMD_COPY: begin
            wr_byte        = s2_valid_ff;
            rsp_item.value = byte_data;
         end
         lzsd_pkg::CMD_END: begin
            rsp_item.kind = lzsd_pkg::KIND_END;
         end
         lzsd_pkg::CMD_FAIL: begin
            rsp_item.kind = lzsd_pkg::KIND_OVERFLOW;
         end
         lzsd_pkg::CMD_RESTART: begin
            rsp_push = 1'b0;
            if (s2_valid_ff) begin
               head_in = WINDOW_BITS'(1);
            end
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
      if (wr_byte) begin
         head_in = head_ff + 1'b1;
      end
      wr_en   = clr_ff || wr_byte;
      wr_addr = clr_ff ? clr_addr_ff : head_ff;
      wr_data = clr_ff ? 8'd0 : byte_data;
      clr_in      = clr_ff && (clr_addr_ff != '1);
      clr_addr_in = clr_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         head_ff     <= WINDOW_BITS'(1);
         idx_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         head_ff     <= head_in;
         idx_ff      <= idx_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff  <= s2_kind_in;
      s2_mem_ff   <= s2_mem_in;
      s2_value_ff <= s2_value_in;
      s2_last_ff  <= s2_last_in;
   end

   // window memory, one write and one registered read per cycle
   // a read of the byte written in the same cycle takes the write data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wr_addr] <= wr_data;
      end
      rd_ff       <= win_mem[rd_addr];
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

endmodule

>>> rtl/lzss_stream_decoder.sv
// lzss_stream_decoder: top level of the streaming lzss decompressor
// depends on lzsd_pkg, lzsd_fifo, lzsd_front and lzsd_back
//
// compressed bytes enter as queue beats (push/full) and are parsed msb first;
// decoded bytes, the end marker and the overflow error leave as queue beats
// (empty/pop), with last set on the final result caused by one input beat.
// the front takes one input beat per cycle while full is low: it merges the
// byte into the pending bit buffer, finds at most one complete token, checks
// the output capacity and queues a command. the back runs one result per
// cycle through the window memory while the result queue has room: a
// literal, end or error gives one result, a restart gives none, and a copy
// gives length+3 bytes (up to 18 with the default 4-bit length). a copy token
// spans 18 bits. the two-entry command queue lets the front keep taking
// beats while the back works through a copy, and a stall on the result side
// holds the back.
// after reset the window is swept to zero, one entry a cycle over all
// 2**WINDOW_BITS entries (8192 by default); full stays high during the sweep
// while capacity writes are taken as usual. a restart beat rewinds the head
// and status but keeps the window contents. the user must see that capacity
// is written only while the block is idle; the block does not enforce this.
module lzss_stream_decoder #(
   parameter int WINDOW_BITS = lzsd_pkg::WINDOW_BITS,
   parameter int LENGTH_BITS = lzsd_pkg::LENGTH_BITS
) (
   input  logic               clock,
   input  logic               reset,
   // input beats
   input  logic               push,
   output logic               full,
   input  lzsd_pkg::req_type  req_data,
   // result beats
   output logic               empty,
   input  logic               pop,
   output lzsd_pkg::rsp_type  rsp_data,
   // output capacity register
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   localparam int CMD_W  = $bits(lzsd_pkg::cmd_kind_type) + 8 + WINDOW_BITS + LENGTH_BITS;
   localparam int RSP_W  = $bits(lzsd_pkg::rsp_type);
   localparam int RCNT_W = $clog2(lzsd_pkg::RSP_DEPTH + 1);
   localparam int CCNT_W = $clog2(lzsd_pkg::CMD_DEPTH + 1);

   logic               accept;
   logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
   logic [CMD_W-1:0]   cmd_wr, cmd_rd;
   logic [CCNT_W-1:0]  cmd_count;
   logic               rsp_push, rsp_full;
   lzsd_pkg::rsp_type  rsp_item;
   logic [RSP_W-1:0]   rsp_rd;
   logic [RCNT_W-1:0]  rsp_count;
   logic               clearing;

   // no beats taken while the window sweep runs
   assign full   = cmd_full || clearing;
   assign accept = push && !full;

   lzsd_front #(
      .WINDOW_BITS (WINDOW_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .CMD_W       (CMD_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr)
   );

   // command queue between parser and copy engine
   lzsd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (lzsd_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .full    (cmd_full),
      .empty   (cmd_empty),
      .count   (cmd_count)
   );

   lzsd_back #(
      .WINDOW_BITS (WINDOW_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .RSP_DEPTH   (lzsd_pkg::RSP_DEPTH),
      .CMD_W       (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item),
      .clearing  (clearing)
   );

   // result queue, doubles as the output register
   lzsd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (lzsd_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (RSP_W'(rsp_item)),
      .pop     (pop),
      .rd_data (rsp_rd),
      .full    (rsp_full),
      .empty   (empty),
      .count   (rsp_count)
   );

   assign rsp_data = lzsd_pkg::rsp_type'(rsp_rd);

   // the back reserves result slots before it issues, so nothing is dropped
   assert property (@(posedge clock) disable iff (reset) rsp_push |-> !rsp_full)
      else $error("result pushed into a full result queue");

   // commands are only taken from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!cmd_empty && (cmd_count != '0)))
      else $error("command popped from an empty queue");

   // no result appears while the window sweep is still running
   assert property (@(posedge clock) disable iff (reset) clearing |-> (empty && !rsp_push))
      else $error("result produced during window clear");

   // a command beat is never lost to a full command queue
   assert property (@(posedge clock) disable iff (reset) cmd_push |-> !cmd_full)
      else $error("command pushed into a full command queue");

endmodule

>>> verif/tb_lzss_stream_decoder.sv
`timescale 1ns / 1ps
// tb_lzss_stream_decoder: self-checking testbench for the lzss stream decoder
// encodes token streams, predicts every decoded result and checks the result beats
// depends on lzsd_pkg and lzss_stream_decoder from rtl
module tb_lzss_stream_decoder;

   // token geometry taken from the package defaults
   localparam int WINDOW_BITS  = lzsd_pkg::WINDOW_BITS;
   localparam int LENGTH_BITS  = lzsd_pkg::LENGTH_BITS;
   localparam int LIT_BITS     = lzsd_pkg::LIT_BITS;
   localparam int MIN_MATCH    = lzsd_pkg::MIN_MATCH;
   localparam int WIN_SIZE     = 1 << WINDOW_BITS;
   localparam int COPY_BITS    = 1 + WINDOW_BITS + LENGTH_BITS;
   // cycles allowed after the last expected result for beats that cause none
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_BEATS  = 90;
   localparam int HOLD_CYCLES   = 300;
   // covers the window sweep after reset plus the slowest run several times over
   localparam int CYCLE_LIMIT   = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   lzsd_pkg::req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   lzsd_pkg::rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   lzss_stream_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // decoder prediction state
   // ---------------------------------------------------------------------------
   logic [7:0]             hist_mem [0:WIN_SIZE-1];   // dictionary copy
   logic [WINDOW_BITS-1:0] dec_head;                  // next dictionary write slot
   logic [31:0]            bit_buf;                   // unparsed bits, right aligned
   int unsigned            bit_cnt;
   logic [31:0]            dec_count;                 // decoded bytes so far
   logic [31:0]            dec_cap;                   // mirror of the capacity register
   bit                     dec_ended;
   bit                     dec_failed;

   lzsd_pkg::rsp_type expected_results [$];           // oldest first
   int      beat_result_cnt;                          // results of the beat being decoded

   // bookkeeping
   int errors = 0;
   int live_beats = 0;
   int n_bytes = 0;
   int n_ends = 0;
   int n_overflows = 0;
   int n_cap_writes = 0;

   // stimulus shaping
   bit send_idle = 1'b1;      // sender may leave gaps
   bit calm = 1'b0;           // last part of the run: no idling on either side
   int hold_len = 0;          // long receiver hold-off requested by a test
   bit sink_holding = 1'b0;

   // bit packer for the encoder side, msb first
   logic [7:0] enc_acc = '0;
   int         enc_n = 0;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] take_bits(int unsigned skip, int unsigned n);
      return (bit_buf >> (bit_cnt - skip - n)) & ((32'd1 << n) - 32'd1);
   endfunction

   function automatic void drop_bits(int unsigned n);
      bit_cnt -= n;
      bit_buf &= (32'd1 << bit_cnt) - 32'd1;
   endfunction

   function automatic void add_result(lzsd_pkg::rsp_kind_type k, logic [7:0] v);
      lzsd_pkg::rsp_type r;
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      expected_results = {expected_results, r};
      beat_result_cnt++;
   endfunction

   // a decoded byte also lands at the dictionary head
   function automatic void add_byte(logic [7:0] v);
      add_result(lzsd_pkg::KIND_BYTE, v);
      hist_mem[dec_head] = v;
      dec_head++;
      dec_count++;
   endfunction

   // works out every result one accepted input beat causes
   function automatic void decode_beat(lzsd_pkg::req_type beat);
      logic [31:0] pos;
      logic [31:0] len;
      lzsd_pkg::rsp_type r;
      beat_result_cnt = 0;
      if (beat.op == lzsd_pkg::OP_RESTART) begin
         // dictionary contents survive a restart
         dec_head   = WINDOW_BITS'(1);
         bit_buf    = 0;
         bit_cnt    = 0;
         dec_count  = 0;
         dec_ended  = 1'b0;
         dec_failed = 1'b0;
         return;
      end
      if (dec_ended || dec_failed) return;

      bit_buf = ((bit_buf << 8) | beat.data_byte) & ((32'd1 << (bit_cnt + 8)) - 32'd1);
      bit_cnt += 8;
      while (bit_cnt >= 1) begin
         if (take_bits(0, 1) == 1) begin
            if (bit_cnt < 1 + LIT_BITS) break;
            pos = take_bits(1, LIT_BITS);
            drop_bits(1 + LIT_BITS);
            if (dec_count >= dec_cap) begin
               dec_failed = 1'b1;
               add_result(lzsd_pkg::KIND_OVERFLOW, 8'd0);
               break;
            end
            add_byte(pos[7:0]);
         end else begin
            if (bit_cnt < 1 + WINDOW_BITS) break;
            pos = take_bits(1, WINDOW_BITS);
            // position zero marks the end of the stream
            if (pos == 0) begin
               drop_bits(1 + WINDOW_BITS);
               dec_ended = 1'b1;
               add_result(lzsd_pkg::KIND_END, 8'd0);
               break;
            end
            if (bit_cnt < COPY_BITS) break;
            len = take_bits(1 + WINDOW_BITS, LENGTH_BITS) + MIN_MATCH;
            drop_bits(COPY_BITS);
            // a copy either fits whole or fails whole
            if (dec_count >= dec_cap || dec_cap - dec_count < len) begin
               dec_failed = 1'b1;
               add_result(lzsd_pkg::KIND_OVERFLOW, 8'd0);
               break;
            end
            for (int i = 0; i < len; i++) add_byte(hist_mem[WINDOW_BITS'(pos + 32'(i))]);
         end
      end

      // leftover bits in the byte after end or error are thrown away
      if (dec_ended || dec_failed) begin
         bit_buf = 0;
         bit_cnt = 0;
      end
      // the newest result of this beat carries last
      if (beat_result_cnt > 0) begin
         r = expected_results.pop_back();
         r.last = 1'b1;
         expected_results = {expected_results, r};
      end
   endfunction

   // ---------------------------------------------------------------------------
   // input side: one beat per call, returns at the accepting edge with push high
   // ---------------------------------------------------------------------------
   task automatic send_beat(lzsd_pkg::op_type op, logic [7:0] data_byte);
      lzsd_pkg::req_type beat;
      beat.op = op;
      beat.data_byte = data_byte;
      if (send_idle && !calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= beat;
      // full is stable at the falling edge, so the next rising edge takes the beat
      forever begin
         @(negedge clock);
         if (!full) break;
      end
      if (op == lzsd_pkg::OP_RESTART || !(dec_ended || dec_failed)) live_beats++;
      decode_beat(beat);
      @(posedge clock);
   endtask

   task automatic put_bits(logic [17:0] code, int n);
      logic [17:0] word;
      word = code << (18 - n);
      repeat (n) begin
         enc_acc = {enc_acc[6:0], word[17]};
         word = word << 1;
         enc_n++;
         if (enc_n == 8) begin
            send_beat(lzsd_pkg::OP_DATA, enc_acc);
            enc_n = 0;
         end
      end
   endtask

   task automatic put_literal(logic [7:0] v);
      put_bits({9'd0, 1'b1, v}, 1 + LIT_BITS);
   endtask

   task automatic put_copy(logic [WINDOW_BITS-1:0] pos, logic [LENGTH_BITS-1:0] len);
      put_bits({1'b0, pos, len}, COPY_BITS);
   endtask

   task automatic put_end();
      put_bits(18'd0, 1 + WINDOW_BITS);
   endtask

   // pad the last partial byte with zeros
   task automatic flush_bits();
      if (enc_n != 0) put_bits(18'd0, 8 - enc_n);
   endtask

   task automatic restart_stream();
      logic [7:0] junk;
      junk = 8'($urandom);
      send_beat(lzsd_pkg::OP_RESTART, junk);
   endtask

   // block idle: nothing owed and time for beats that cause no result
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] cap);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dec_cap = cap;
      n_cap_writes++;
   endtask

   // ---------------------------------------------------------------------------
   // result side: pop with random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : result_sink
      @(posedge clock);
      forever begin
         if (hold_len != 0) begin
            sink_holding = 1'b1;
            pop <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            sink_holding = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // a result beat is taken at the rising edge after this falling edge
   always @(negedge clock) begin : result_check
      lzsd_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected: kind %0d value %h last %b",
                     $time, rsp_data.kind, rsp_data.value, rsp_data.last);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.kind !== want.kind) begin
               errors++;
               $display("%0t: kind expected %0d, actual %0d", $time, want.kind, rsp_data.kind);
            end
            if (rsp_data.value !== want.value) begin
               errors++;
               $display("%0t: value expected %h, actual %h", $time, want.value, rsp_data.value);
            end
            if (rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: last expected %b, actual %b", $time, want.last, rsp_data.last);
            end
            case (want.kind)
               lzsd_pkg::KIND_BYTE: n_bytes++;
               lzsd_pkg::KIND_END:  n_ends++;
               default:             n_overflows++;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------------------
   int unsigned cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_lzss_stream_decoder: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // literals at the byte extremes, short, overlapping and wrapping copies, end
   task automatic test_tokens();
      put_literal(8'h00);
      put_literal(8'hFF);
      put_literal(8'h5A);
      put_literal(8'hA5);
      put_copy(13'd1, 4'd0);                 // shortest copy
      put_copy(13'd7, 4'd15);                // longest copy, reads what it writes
      put_copy(13'd8191, 4'd2);              // wraps past the top of the window
      put_end();
      flush_bits();
      // beats after the end are dropped
      send_beat(lzsd_pkg::OP_DATA, 8'h00);
      send_beat(lzsd_pkg::OP_DATA, 8'hFF);
   endtask

   // capacity limits on literals and copies, restart, capacity under the count
   task automatic test_capacity();
      // exact fit, then a literal one past the limit
      write_capacity(32'd5);
      restart_stream();
      put_literal(8'h3C);
      put_literal(8'hC3);
      put_copy(13'd1, 4'd0);
      put_literal(8'h81);
      flush_bits();
      send_beat(lzsd_pkg::OP_DATA, 8'hFF);
      // copy longer than the room left fails whole
      write_capacity(32'd4);
      restart_stream();
      put_literal(8'h7E);
      put_copy(13'd2, 4'd1);
      flush_bits();
      // no room at all
      write_capacity(32'd0);
      restart_stream();
      put_literal(8'h11);
      flush_bits();
      // capacity lowered below the bytes already out, mid token
      write_capacity(32'hFFFF_FFFF);
      restart_stream();
      put_literal(8'h01);
      put_literal(8'h02);
      put_literal(8'h04);
      write_capacity(32'd1);
      put_literal(8'h08);
      flush_bits();
   endtask

   // receiver stops for a long stretch while the sender keeps pushing
   task automatic test_backpressure();
      logic [7:0] b;
      write_capacity(32'hFFFF_FFFF);
      restart_stream();
      send_idle = 1'b0;
      push <= 1'b0;
      hold_len = HOLD_CYCLES;
      while (!sink_holding) @(posedge clock);
      repeat (12) begin
         b = 8'($urandom);
         put_literal(b);
      end
      repeat (4) put_copy(dec_head - 13'd5, 4'd15);
      put_end();
      flush_bits();
      send_idle = 1'b1;
   endtask

   // mostly well-formed streams with random tokens, some broken or truncated
   task automatic test_random_streams();
      int                     target;
      int                     n_tok;
      int                     pick;
      logic [31:0]            cap;
      logic [WINDOW_BITS-1:0] pos;
      logic [WINDOW_BITS-1:0] step_back;
      logic [LENGTH_BITS-1:0] len;
      logic [7:0]             b;
      target = live_beats + RANDOM_BEATS;
      while (live_beats < target) begin
         // the tail of the run goes without idling
         if (live_beats > target - RANDOM_BEATS / 5) calm = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       cap = lzsd_pkg::CAP_RESET;
               1:       cap = 32'd0;
               2:       cap = $urandom_range(1, 40);
               3:       cap = $urandom_range(41, 400);
               default: cap = $urandom;
            endcase
            write_capacity(cap);
         end
         // now and then no restart, so a finished stream ignores its bytes
         if ($urandom_range(0, 7) != 0) restart_stream();
         n_tok = $urandom_range(1, 16);
         repeat (n_tok) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               b = 8'($urandom);
               put_literal(b);
            end else begin
               if (pick < 8) begin
                  step_back = WINDOW_BITS'($urandom_range(1, 64));
                  pos = dec_head - step_back;
               end else begin
                  pos = WINDOW_BITS'($urandom_range(1, WIN_SIZE - 1));
               end
               if ($urandom_range(0, 3) == 0) len = LENGTH_BITS'($urandom_range(0, 15));
               else len = LENGTH_BITS'($urandom_range(0, 4));
               put_copy(pos, len);
            end
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            put_end();
            flush_bits();
            repeat ($urandom_range(0, 2)) send_beat(lzsd_pkg::OP_DATA, 8'h00);
         end else if (pick < 8) begin
            // broken tail: random bytes where a token should continue
            flush_bits();
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom);
               send_beat(lzsd_pkg::OP_DATA, b);
            end
         end else begin
            flush_bits();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : main
      hist_mem   = '{default: 8'd0};
      dec_head   = WINDOW_BITS'(1);
      bit_buf    = 0;
      bit_cnt    = 0;
      dec_count  = 0;
      dec_cap    = lzsd_pkg::CAP_RESET;
      dec_ended  = 1'b0;
      dec_failed = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full stays high while the window is swept after reset
      test_tokens();
      test_capacity();
      test_backpressure();
      test_random_streams();

      wait_idle();
      if (expected_results.size() != 0) begin
         $display("%0t: %0d more results expected, none arrived",
                  $time, expected_results.size());
      end
      errors += expected_results.size();
      $display("tb_lzss_stream_decoder: %0d live input beats, %0d capacity writes",
               live_beats, n_cap_writes);
      $display("tb_lzss_stream_decoder: checked %0d bytes, %0d ends, %0d overflows",
               n_bytes, n_ends, n_overflows);
      if (errors == 0) begin
         $display("tb_lzss_stream_decoder: done, clean");
      end else begin
         $display("tb_lzss_stream_decoder: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lzsd_pkg.sv
rtl/lzsd_fifo.sv
rtl/lzsd_front.sv
rtl/lzsd_back.sv
rtl/lzss_stream_decoder.sv
verif/tb_lzss_stream_decoder.sv
